>>> sv/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and fixed constants of the soft photon strip filter.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int FRAC_W  = 16;
	localparam int CLAMP_W = 32;
	localparam int SQ_W    = 2 * CLAMP_W;
	localparam int RAD_W   = SQ_W + 2;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int ITER_W  = 6;
	localparam int CIDX_W  = 4;
	localparam int MCNT_W  = 5;
	localparam int REG_W   = 2;

	localparam logic [REG_W-1:0] REG_SINGLE_FRAC = 2'd0;
	localparam logic [REG_W-1:0] REG_MULTI_FRAC  = 2'd1;

	localparam logic [CLAMP_W-1:0] CLAMP_MAX = 32'h8000_0000;

	typedef struct packed {
		logic clear;
		logic insert;
		logic pop;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/sfs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_cell
// One slot of the sorting chain: holds one cluster word, keyed by pt.
// ----------------------------------------------------------------------------
module sfs_cell #(
	parameter int DW = 120,
	parameter int KW = 23
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire sfs_pkg::cell_ctrl_t ctrl,
	input  wire  [DW-1:0]           new_data,
	input  wire  [DW-1:0]           left_data,
	input  wire                     left_valid,
	input  wire                     left_gt,
	input  wire  [DW-1:0]           right_data,
	input  wire                     right_valid,
	output logic [DW-1:0]           data,
	output logic                    valid,
	output logic                    gt
);

	logic [DW-1:0] data_q;
	logic          valid_q;

	assign gt    = !valid_q || (data_q[DW-1 -: KW] > new_data[DW-1 -: KW]);
	assign data  = data_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (gt) begin
				valid_q <= left_gt ? left_valid : 1'b1;
			end
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && !ctrl.clear) begin
			if (gt) begin
				data_q <= left_gt ? left_data : new_data;
			end
		end else if (ctrl.pop && !ctrl.clear) begin
			data_q <= right_data;
		end
	end

endmodule
`default_nettype wire

>>> sv/sfs_ptcalc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_ptcalc
// Transverse momentum: clamp, square, sum, then one root bit per cycle.
// ----------------------------------------------------------------------------
module sfs_ptcalc #(
	parameter int IN_W = 30,
	parameter int PT_W = 23
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  signed [IN_W-1:0] op_x,
	input  wire  signed [IN_W-1:0] op_y,
	output logic                  done,
	output logic [PT_W-1:0]       pt
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SUM  = 2'd1;
	localparam logic [1:0] PH_ITER = 2'd2;

	localparam int ROOT_W = sfs_pkg::ROOT_W;
	localparam int REM_W  = ROOT_W + 2;

	function automatic logic [sfs_pkg::CLAMP_W-1:0] clamp_mag(input logic signed [IN_W-1:0] v);
		logic [IN_W-1:0] m;
		logic [63:0]     w;
		m = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
		w = 64'(m);
		if (w > 64'(sfs_pkg::CLAMP_MAX)) begin
			return sfs_pkg::CLAMP_MAX;
		end
		return w[sfs_pkg::CLAMP_W-1:0];
	endfunction

	logic [1:0]                    phase_q;
	logic [sfs_pkg::ITER_W-1:0]    iter_q;
	logic [sfs_pkg::SQ_W-1:0]      sqx_q, sqy_q;
	logic [sfs_pkg::RAD_W-1:0]     rad_q;
	logic [REM_W-1:0]              rem_q;
	logic [ROOT_W-1:0]             root_q;
	logic                          done_q;
	logic [PT_W-1:0]               pt_q;
	logic [sfs_pkg::CLAMP_W-1:0]   ax, ay;
	logic [REM_W-1:0]              rem_in, trial;
	logic                          take;
	logic [REM_W-1:0]              rem_nx;
	logic [ROOT_W-1:0]             root_nx;

	assign ax = clamp_mag(op_x);
	assign ay = clamp_mag(op_y);

	assign rem_in  = {rem_q[REM_W-3:0], rad_q[sfs_pkg::RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign take    = rem_in >= trial;
	assign rem_nx  = take ? rem_in - trial : rem_in;
	assign root_nx = {root_q[ROOT_W-2:0], take};

	always_ff @(posedge clk) begin
		if (start) begin
			sqx_q <= sfs_pkg::SQ_W'(ax) * sfs_pkg::SQ_W'(ax);
			sqy_q <= sfs_pkg::SQ_W'(ay) * sfs_pkg::SQ_W'(ay);
		end
		if (phase_q == PH_SUM) begin
			rad_q  <= sfs_pkg::RAD_W'(sqx_q) + sfs_pkg::RAD_W'(sqy_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (phase_q == PH_ITER) begin
			rad_q  <= {rad_q[sfs_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= root_nx;
			if (iter_q == sfs_pkg::ITER_W'(ROOT_W - 1)) begin
				pt_q <= (|root_nx[ROOT_W-1:PT_W]) ? {PT_W{1'b1}} : root_nx[PT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_SUM;
					end
				end
				PH_SUM: begin
					phase_q <= PH_ITER;
					iter_q  <= '0;
				end
				PH_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == sfs_pkg::ITER_W'(ROOT_W - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign pt   = pt_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> phase_q == PH_IDLE)
		else $error("pt done outside idle");
	assert property (@(posedge clk) disable iff (!arst_n) phase_q <= PH_ITER)
		else $error("pt phase out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ITER) |-> (iter_q <= sfs_pkg::ITER_W'(ROOT_W - 1)))
		else $error("pt iteration overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SUM) |=> (phase_q == PH_ITER))
		else $error("pt sum not followed by root");

endmodule
`default_nettype wire

>>> sv/soft_photon_strip_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_photon_strip_filter_top
// Sorts sub-clusters by pt in a cell chain and strips soft ones from a total.
// Loading: one word per cycle while item_stall is low; each cluster enters
// its sorted slot on arrival while the chain has room. Strip: each tested
// cluster waits on the one-bit-per-cycle pt root of the total; once one is
// kept, the rest go untested. A set ends with removed pt and the summary word.
// Reset clears the chain, totals and fractions; the set state clears per set.
// ----------------------------------------------------------------------------
module soft_photon_strip_filter_top #(
	parameter int MAX_CANDS = 16,
	parameter int MOM_WIDTH = 24
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [sfs_pkg::REG_W-1:0]   cfg_index,
	input  wire  [sfs_pkg::FRAC_W-1:0]  cfg_data,
	input  wire                         item_valid,
	output logic                        item_stall,
	input  wire                         kind,
	input  wire  signed [MOM_WIDTH-1:0] mom_x,
	input  wire  signed [MOM_WIDTH-1:0] mom_y,
	input  wire  signed [MOM_WIDTH-1:0] mom_z,
	input  wire  signed [MOM_WIDTH-1:0] energy_in,
	input  wire  [MOM_WIDTH-2:0]        trans_mom,
	input  wire                         multi_photon,
	input  wire                         final_item,
	output logic                        result_valid,
	input  wire                         result_stall,
	output logic                        out_kind,
	output logic [sfs_pkg::CIDX_W-1:0]  cluster_index,
	output logic                        moved,
	output logic signed [MOM_WIDTH-1:0] new_x,
	output logic signed [MOM_WIDTH-1:0] new_y,
	output logic signed [MOM_WIDTH-1:0] new_z,
	output logic signed [MOM_WIDTH-1:0] new_energy,
	output logic [MOM_WIDTH-2:0]        removed_pt,
	output logic [sfs_pkg::MCNT_W-1:0]  moved_count,
	output logic                        last_out
);

	localparam int MW    = MOM_WIDTH;
	localparam int PT_W  = MOM_WIDTH - 1;
	localparam int IW    = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
	localparam int CNT_W = $clog2(MAX_CANDS + 1);
	localparam int RW    = MW + CNT_W + 1;
	localparam int DW    = PT_W + 1 + IW + 4 * MW;
	localparam int PW    = PT_W + sfs_pkg::FRAC_W;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_TP   = 3'd1;
	localparam logic [2:0] S_TPW  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_RPT  = 3'd5;
	localparam logic [2:0] S_RPTW = 3'd6;
	localparam logic [2:0] S_SUM  = 3'd7;

	function automatic logic [MW-1:0] sat_mom(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] hi, lo;
		hi = $signed({{(RW-MW+1){1'b0}}, {(MW-1){1'b1}}});
		lo = $signed({{(RW-MW+1){1'b1}}, {(MW-1){1'b0}}});
		if (v > hi) begin
			return hi[MW-1:0];
		end
		if (v < lo) begin
			return lo[MW-1:0];
		end
		return v[MW-1:0];
	endfunction

	logic [2:0]                 state_q;
	logic [sfs_pkg::FRAC_W-1:0] frac_single_q, frac_multi_q;
	logic [CNT_W-1:0]           count_q, mvn_q;
	logic                       stop_q, mv_q;
	logic signed [RW-1:0]       run_x_q, run_y_q, run_z_q, run_e_q;
	logic signed [RW-1:0]       ini_x_q, ini_y_q;
	logic [PW-1:0]              prod_q;
	logic [PT_W-1:0]            rpt_q;

	logic                       out_valid_q, out_kind_q, moved_q, last_q;
	logic [sfs_pkg::CIDX_W-1:0] cidx_q;
	logic [MW-1:0]              nx_q, ny_q, nz_q, ne_q;
	logic [PT_W-1:0]            rpt_out_q;
	logic [sfs_pkg::MCNT_W-1:0] mcnt_q;

	sfs_pkg::cell_ctrl_t        cctrl;
	logic [DW-1:0]              new_word;
	logic [DW-1:0]              cdata [MAX_CANDS];
	logic [MAX_CANDS-1:0]       cvalid, cgt;

	logic                       in_acc, out_free;
	logic                       pc_start, pc_done;
	logic signed [RW-1:0]       pc_x, pc_y;
	logic [PT_W-1:0]            pc_pt;

	logic [PT_W-1:0]            h_pt;
	logic                       h_multi;
	logic [IW-1:0]              h_idx;
	logic signed [MW-1:0]       h_x, h_y, h_z, h_e;
	logic [sfs_pkg::FRAC_W-1:0] h_frac;
	logic [IW+sfs_pkg::CIDX_W-1:0] h_idx_w;
	logic [CNT_W+sfs_pkg::MCNT_W-1:0] mvn_w;

	assign in_acc   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign item_stall = (state_q != S_LOAD);

	assign new_word = {trans_mom, multi_photon, IW'(count_q), mom_x, mom_y, mom_z, energy_in};

	assign {h_pt, h_multi, h_idx, h_x, h_y, h_z, h_e} = cdata[0];
	assign h_frac  = h_multi ? frac_multi_q : frac_single_q;
	assign h_idx_w = (IW + sfs_pkg::CIDX_W)'(h_idx);
	assign mvn_w   = (CNT_W + sfs_pkg::MCNT_W)'(mvn_q);

	always_comb begin
		cctrl.clear  = (in_acc && !kind) || (state_q == S_SUM && out_free);
		cctrl.insert = in_acc && kind && (count_q < CNT_W'(MAX_CANDS));
		cctrl.pop    = (state_q == S_EMIT) && out_free;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_CANDS; gi++) begin : g_cell
			logic [DW-1:0] ld, rd;
			logic          lv, lg, rv;
			if (gi == 0) begin : g_first
				assign ld = '0;
				assign lv = 1'b0;
				assign lg = 1'b0;
			end else begin : g_mid
				assign ld = cdata[gi-1];
				assign lv = cvalid[gi-1];
				assign lg = cgt[gi-1];
			end
			if (gi == MAX_CANDS - 1) begin : g_last
				assign rd = '0;
				assign rv = 1'b0;
			end else begin : g_rest
				assign rd = cdata[gi+1];
				assign rv = cvalid[gi+1];
			end
			sfs_cell #(
				.DW(DW),
				.KW(PT_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (cctrl),
				.new_data   (new_word),
				.left_data  (ld),
				.left_valid (lv),
				.left_gt    (lg),
				.right_data (rd),
				.right_valid(rv),
				.data       (cdata[gi]),
				.valid      (cvalid[gi]),
				.gt         (cgt[gi])
			);
		end
	endgenerate

	assign pc_start = (state_q == S_TP && !stop_q) || (state_q == S_RPT);
	assign pc_x     = (state_q == S_RPT) ? run_x_q - ini_x_q : run_x_q;
	assign pc_y     = (state_q == S_RPT) ? run_y_q - ini_y_q : run_y_q;

	sfs_ptcalc #(
		.IN_W(RW),
		.PT_W(PT_W)
	) u_ptcalc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (pc_start),
		.op_x  (pc_x),
		.op_y  (pc_y),
		.done  (pc_done),
		.pt    (pc_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_single_q <= '0;
			frac_multi_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfs_pkg::REG_SINGLE_FRAC: frac_single_q <= cfg_data;
				sfs_pkg::REG_MULTI_FRAC:  frac_multi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TPW && pc_done) begin
			prod_q <= PW'(h_frac) * PW'(pc_pt);
		end
		if (state_q == S_RPTW && pc_done) begin
			rpt_q <= pc_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			mvn_q   <= '0;
			stop_q  <= 1'b0;
			mv_q    <= 1'b0;
			run_x_q <= '0;
			run_y_q <= '0;
			run_z_q <= '0;
			run_e_q <= '0;
			ini_x_q <= '0;
			ini_y_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (!kind) begin
							run_x_q <= RW'(mom_x);
							run_y_q <= RW'(mom_y);
							run_z_q <= RW'(mom_z);
							run_e_q <= RW'(energy_in);
							ini_x_q <= RW'(mom_x);
							ini_y_q <= RW'(mom_y);
							count_q <= '0;
						end else if (cctrl.insert) begin
							count_q <= count_q + 1'b1;
						end
						if (final_item) begin
							if (!kind || (count_q == '0 && !cctrl.insert)) begin
								state_q <= S_RPT;
							end else begin
								state_q <= S_TP;
							end
						end
					end
				end
				S_TP: begin
					if (stop_q) begin
						mv_q    <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_TPW;
					end
				end
				S_TPW: begin
					if (pc_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					mv_q    <= {h_pt, {sfs_pkg::FRAC_W{1'b0}}} < prod_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (mv_q) begin
							run_x_q <= run_x_q - RW'(h_x);
							run_y_q <= run_y_q - RW'(h_y);
							run_z_q <= run_z_q - RW'(h_z);
							run_e_q <= run_e_q - RW'(h_e);
							mvn_q   <= mvn_q + 1'b1;
						end else begin
							stop_q <= 1'b1;
						end
						count_q <= count_q - 1'b1;
						state_q <= (count_q == CNT_W'(1)) ? S_RPT : S_TP;
					end
				end
				S_RPT: begin
					state_q <= S_RPTW;
				end
				S_RPTW: begin
					if (pc_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (out_free) begin
						count_q <= '0;
						mvn_q   <= '0;
						stop_q  <= 1'b0;
						run_x_q <= '0;
						run_y_q <= '0;
						run_z_q <= '0;
						run_e_q <= '0;
						ini_x_q <= '0;
						ini_y_q <= '0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_SUM && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_kind_q <= 1'b0;
			cidx_q     <= h_idx_w[sfs_pkg::CIDX_W-1:0];
			moved_q    <= mv_q;
			nx_q       <= '0;
			ny_q       <= '0;
			nz_q       <= '0;
			ne_q       <= '0;
			rpt_out_q  <= '0;
			mcnt_q     <= '0;
			last_q     <= 1'b0;
		end else if (state_q == S_SUM && out_free) begin
			out_kind_q <= 1'b1;
			cidx_q     <= '0;
			moved_q    <= 1'b0;
			nx_q       <= sat_mom(run_x_q);
			ny_q       <= sat_mom(run_y_q);
			nz_q       <= sat_mom(run_z_q);
			ne_q       <= sat_mom(run_e_q);
			rpt_out_q  <= rpt_q;
			mcnt_q     <= mvn_w[sfs_pkg::MCNT_W-1:0];
			last_q     <= 1'b1;
		end
	end

	assign result_valid  = out_valid_q;
	assign out_kind      = out_kind_q;
	assign cluster_index = cidx_q;
	assign moved         = moved_q;
	assign new_x         = nx_q;
	assign new_y         = ny_q;
	assign new_z         = nz_q;
	assign new_energy    = ne_q;
	assign removed_pt    = rpt_out_q;
	assign moved_count   = mcnt_q;
	assign last_out      = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(MAX_CANDS))
		else $error("cluster count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) $countones(cvalid) == 32'(count_q))
		else $error("chain occupancy differs from count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TP || state_q == S_CMP || state_q == S_EMIT) |-> cvalid[0])
		else $error("strip step on empty chain head");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> result_valid && !out_kind)
		else $error("verdict word not presented");

endmodule
`default_nettype wire

>>> tb/soft_photon_strip_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_photon_strip_filter_top_tb
// Sends total and sub-cluster words in sets, predicts the per-cluster verdicts
// and the summary word, and compares every result field by field under
// several fraction settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module soft_photon_strip_filter_top_tb;

	localparam int NSLOT = 16;
	localparam int MW = 24;
	localparam logic [sfs_pkg::REG_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [sfs_pkg::REG_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_CLUSTER = 1'b1;
	localparam logic OUT_VERDICT = 1'b0;
	localparam logic OUT_SUMMARY = 1'b1;
	localparam longint MOM_HI = 64'sd8388607;
	localparam longint MOM_LO = -64'sd8388608;
	localparam longint PT_HI = 64'd8388607;

	typedef struct {
		logic                       okind;
		logic [sfs_pkg::CIDX_W-1:0] idx;
		logic                       mv;
		logic [MW-1:0]              nx, ny, nz, ne;
		logic [MW-2:0]              rpt;
		logic [sfs_pkg::MCNT_W-1:0] mcnt;
		logic                       last;
	} strip_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sfs_pkg::REG_W-1:0] cfg_index = '0;
	logic [sfs_pkg::FRAC_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic kind = 1'b0;
	logic signed [MW-1:0] mom_x = '0, mom_y = '0, mom_z = '0, energy_in = '0;
	logic [MW-2:0] trans_mom = '0;
	logic multi_photon = 1'b0;
	logic final_item = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic out_kind;
	logic [sfs_pkg::CIDX_W-1:0] cluster_index;
	logic moved;
	logic signed [MW-1:0] new_x, new_y, new_z, new_energy;
	logic [MW-2:0] removed_pt;
	logic [sfs_pkg::MCNT_W-1:0] moved_count;
	logic last_out;

	soft_photon_strip_filter_top #(.MAX_CANDS(NSLOT), .MOM_WIDTH(MW)) dut (.*);

	always #10 clk = ~clk;

	// predictor state
	longint unsigned single_frac = 0, multi_frac = 0;
	longint slot_x[NSLOT], slot_y[NSLOT], slot_z[NSLOT], slot_e[NSLOT];
	longint unsigned slot_pt[NSLOT];
	bit slot_multi[NSLOT];
	int unsigned slot_order[NSLOT];
	int unsigned slot_count = 0;
	longint run_tot[4] = '{0, 0, 0, 0};
	longint init_tot[4] = '{0, 0, 0, 0};

	strip_word_t expected_q[$];
	int errors = 0;
	int items_sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned clamp_mag(longint v);
		longint unsigned a;
		a = (v < 0) ? longint'(-v) : longint'(v);
		if (a > (64'd1 << 31)) a = 64'd1 << 31;
		return a;
	endfunction

	function automatic longint unsigned pt_from(longint x, longint y);
		longint unsigned ax, ay, r;
		ax = clamp_mag(x);
		ay = clamp_mag(y);
		r = root_floor(ax * ax + ay * ay);
		return (r > PT_HI) ? PT_HI : r;
	endfunction

	function automatic logic [MW-1:0] sat_mom(longint v);
		if (v > MOM_HI) v = MOM_HI;
		if (v < MOM_LO) v = MOM_LO;
		return v[MW-1:0];
	endfunction

	function automatic void predict_strip(logic k, logic signed [MW-1:0] x, y, z, e,
			logic [MW-2:0] pt, logic mp, logic fin);
		int unsigned n, k2, cur, stripped, c;
		longint unsigned tp, frac;
		strip_word_t w;
		if (k == KIND_TOTAL) begin
			run_tot = '{longint'(x), longint'(y), longint'(z), longint'(e)};
			init_tot = run_tot;
			slot_count = 0;
		end else if (slot_count < NSLOT) begin
			n = slot_count;
			slot_x[n] = x; slot_y[n] = y; slot_z[n] = z; slot_e[n] = e;
			slot_pt[n] = pt;
			slot_multi[n] = mp;
			slot_count = n + 1;
		end
		if (!fin) return;
		n = slot_count;
		for (int i = 0; i < n; i++) begin
			cur = i;
			k2 = i;
			while (k2 > 0 && slot_pt[slot_order[k2-1]] > slot_pt[cur]) begin
				slot_order[k2] = slot_order[k2-1];
				k2--;
			end
			slot_order[k2] = cur;
		end
		stripped = 0;
		while (stripped < n) begin
			c = slot_order[stripped];
			tp = pt_from(run_tot[0], run_tot[1]);
			frac = slot_multi[c] ? multi_frac : single_frac;
			if (!((slot_pt[c] << 16) < frac * tp)) break;
			run_tot[0] -= slot_x[c];
			run_tot[1] -= slot_y[c];
			run_tot[2] -= slot_z[c];
			run_tot[3] -= slot_e[c];
			stripped++;
		end
		for (int i = 0; i < n; i++) begin
			w = '{default: '0};
			w.okind = OUT_VERDICT;
			w.idx = sfs_pkg::CIDX_W'(slot_order[i]);
			w.mv = (i < stripped);
			expected_q.insert(expected_q.size(), w);
		end
		w = '{default: '0};
		w.okind = OUT_SUMMARY;
		w.nx = sat_mom(run_tot[0]);
		w.ny = sat_mom(run_tot[1]);
		w.nz = sat_mom(run_tot[2]);
		w.ne = sat_mom(run_tot[3]);
		w.rpt = (MW-1)'(pt_from(run_tot[0] - init_tot[0], run_tot[1] - init_tot[1]));
		w.mcnt = sfs_pkg::MCNT_W'(stripped);
		w.last = 1'b1;
		expected_q.insert(expected_q.size(), w);
		slot_count = 0;
		run_tot = '{0, 0, 0, 0};
		init_tot = '{0, 0, 0, 0};
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		strip_word_t w;
		result_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				w = expected_q.pop_front();
				check_field("out_kind", w.okind, out_kind);
				check_field("cluster_index", w.idx, cluster_index);
				check_field("moved", w.mv, moved);
				check_field("new_x", w.nx, $unsigned(new_x));
				check_field("new_y", w.ny, $unsigned(new_y));
				check_field("new_z", w.nz, $unsigned(new_z));
				check_field("new_energy", w.ne, $unsigned(new_energy));
				check_field("removed_pt", w.rpt, removed_pt);
				check_field("moved_count", w.mcnt, moved_count);
				check_field("last_out", w.last, last_out);
			end
		end
	end

	task automatic send_word(logic k, logic signed [MW-1:0] x, y, z, e,
			logic [MW-2:0] pt, logic mp, logic fin);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		mom_x <= x; mom_y <= y; mom_z <= z; energy_in <= e;
		trans_mom <= pt;
		multi_photon <= mp;
		final_item <= fin;
		do @(posedge clk); while (item_stall);
		predict_strip(k, x, y, z, e, pt, mp, fin);
		items_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [sfs_pkg::REG_W-1:0] idx, logic [sfs_pkg::FRAC_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sfs_pkg::REG_SINGLE_FRAC) single_frac = val;
		else if (idx == sfs_pkg::REG_MULTI_FRAC) multi_frac = val;
	endtask

	task automatic set_fractions(logic [sfs_pkg::FRAC_W-1:0] s,
			logic [sfs_pkg::FRAC_W-1:0] m);
		wait_drained();
		write_reg(sfs_pkg::REG_SINGLE_FRAC, s);
		write_reg(sfs_pkg::REG_MULTI_FRAC, m);
		write_reg(REG_SPARE_A, ~s);
		write_reg(REG_SPARE_B, ~m);
		@(posedge clk);
	endtask

	function automatic logic signed [MW-1:0] rand_mom();
		case ($urandom_range(3))
			0: return MW'($urandom);
			1: return $urandom_range(1) ? MOM_HI[MW-1:0] : MOM_LO[MW-1:0];
			2: return MW'($urandom_range(4000) - 2000);
			default: return MW'($urandom_range(4000000) - 2000000);
		endcase
	endfunction

	function automatic logic [MW-2:0] rand_pt();
		case ($urandom_range(3))
			0: return (MW-1)'($urandom);
			1: return $urandom_range(1) ? PT_HI[MW-2:0] : '0;
			default: return (MW-1)'($urandom_range(50000));
		endcase
	endfunction

	task automatic test_directed();
		set_fractions(16'h8000, 16'hFFFF);
		// empty set closed on its total word
		send_word(KIND_TOTAL, 24'sd300000, -24'sd400000, 24'sd5, -24'sd7, '0, 1'b0, 1'b1);
		// clusters with no total: zero total pt stops stripping
		send_word(KIND_CLUSTER, 24'sd10, 24'sd20, 24'sd30, 24'sd40, 23'd0, 1'b0, 1'b1);
		// total mid-set restarts the set
		send_word(KIND_TOTAL, 24'sd1000, 24'sd1000, 24'sd0, 24'sd0, '0, 1'b0, 1'b0);
		send_word(KIND_CLUSTER, 24'sd9, 24'sd9, 24'sd9, 24'sd9, 23'd5, 1'b1, 1'b0);
		send_word(KIND_TOTAL, MOM_LO[MW-1:0], MOM_LO[MW-1:0], MOM_HI[MW-1:0],
			MOM_LO[MW-1:0], PT_HI[MW-2:0], 1'b1, 1'b0);
		send_word(KIND_CLUSTER, MOM_HI[MW-1:0], MOM_HI[MW-1:0], MOM_LO[MW-1:0],
			MOM_HI[MW-1:0], 23'd1, 1'b0, 1'b1);
		// full set plus one ignored cluster carrying the final mark
		send_word(KIND_TOTAL, MOM_HI[MW-1:0], MOM_LO[MW-1:0], MOM_LO[MW-1:0],
			MOM_HI[MW-1:0], '0, 1'b0, 1'b0);
		for (int i = 0; i < NSLOT + 1; i++)
			send_word(KIND_CLUSTER, (i % 2) ? MOM_LO[MW-1:0] : MW'(1000 * i),
				MW'(-500 * i), MOM_HI[MW-1:0], MW'(-i),
				(i == 3) ? PT_HI[MW-2:0] : (MW-1)'(100 * (i % 5)), i[0], i == NSLOT);
	endtask

	task automatic test_random_sets(int quota);
		int target, n, mid;
		target = items_sent + quota;
		while (items_sent < target) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(NSLOT + 2) : $urandom_range(6);
			mid = ($urandom_range(9) == 0) ? $urandom_range(n) : -1;
			if ($urandom_range(9) != 0)
				send_word(KIND_TOTAL, rand_mom(), rand_mom(), rand_mom(), rand_mom(),
					rand_pt(), 1'($urandom_range(1)), n == 0);
			for (int i = 0; i < n; i++) begin
				if (i == mid)
					send_word(KIND_TOTAL, rand_mom(), rand_mom(), rand_mom(), rand_mom(),
						rand_pt(), 1'($urandom_range(1)), 1'b0);
				send_word(KIND_CLUSTER, rand_mom(), rand_mom(), rand_mom(), rand_mom(),
					rand_pt(), 1'($urandom_range(1)), i == n - 1);
			end
			if (n == 0 && slot_count == 0 && run_tot[0] == 0 && $urandom_range(1))
				send_word(KIND_CLUSTER, rand_mom(), rand_mom(), rand_mom(), rand_mom(),
					rand_pt(), 1'($urandom_range(1)), 1'b1);
		end
	endtask

	task automatic test_phase(int gp, int sp, logic [sfs_pkg::FRAC_W-1:0] s,
			logic [sfs_pkg::FRAC_W-1:0] m);
		set_fractions(s, m);
		gap_pct = gp;
		stall_pct = sp;
		test_random_sets(45);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (50) @(posedge clk);
		test_directed();
		test_phase(0, 0, 16'hFFFF, 16'hFFFF);
		test_phase(70, 0, 16'h0000, 16'h0000);
		test_phase(0, 70, sfs_pkg::FRAC_W'($urandom), sfs_pkg::FRAC_W'($urandom));
		test_phase(30, 30, 16'h2000, 16'hC000);
		gap_pct = 0;
		stall_pct = 0;
		wait_drained();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
